>>> rtl/ssum_pkg.sv
// Shared types and constants for the sorted set union merge core.
// No dependencies; imported by every module under rtl/.
package ssum_pkg;

  localparam int VALUE_W        = 32;
  localparam int SSUM_SET_DEPTH = 16;

  typedef enum logic [1:0] {
    MODE_INS_A = 2'd0,
    MODE_INS_B = 2'd1,
    MODE_UNION = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  // Command into one chain of cells
  typedef struct packed {
    logic ins;
    logic pop;
  } chain_cmd_t;

  // Status out of one chain: head cell and occupancy flags
  typedef struct packed {
    logic [VALUE_W-1:0] head;
    logic               head_vld;
    logic               next_vld;
    logic               full;
  } chain_stat_t;

endpackage

>>> rtl/sorted_set_union_merge_core.sv
// Top level of the sorted set union merge core: two cell chains and control.
// Depends on ssum_pkg, ssum_cell and ssum_chain.
//
//   channel | signals                                  | dir
//   --------+------------------------------------------+-----
//   in      | in_valid, in_ready, mode, value          | in
//   out     | out_valid, out_ready, value_res,         | out
//           | has_value, last, overflow                |
//
// On an insert every cell compares and shifts in parallel.
// In a union the heads of the two chains are compared and one element leaves
// per accepted output. Input is not taken while a union run is being emitted;
// out_ready low holds the current element. Reset empties both sets at once;
// no clearing pass.
module sorted_set_union_merge_core #(
  parameter int SET_DEPTH = ssum_pkg::SSUM_SET_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        mode,
  input  logic signed [ssum_pkg::VALUE_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ssum_pkg::VALUE_W-1:0] value_res,
  output logic                              has_value,
  output logic                              last,
  output logic                              overflow
);
  import ssum_pkg::*;

  state_t      state, state_next;
  logic        dropped;
  chain_cmd_t  a_cmd, b_cmd;
  chain_stat_t a_st, b_st;
  logic        in_acc, out_acc;
  logic        pick_a, pick_b;
  logic        rem_a, rem_b;
  logic signed [VALUE_W-1:0] a_head, b_head;

  ssum_chain #(.SET_DEPTH(SET_DEPTH)) u_chain_a (
    .clk     (clk),
    .rst     (rst),
    .cmd     (a_cmd),
    .ins_val (value),
    .stat    (a_st)
  );

  ssum_chain #(.SET_DEPTH(SET_DEPTH)) u_chain_b (
    .clk     (clk),
    .rst     (rst),
    .cmd     (b_cmd),
    .ins_val (value),
    .stat    (b_st)
  );

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  assign a_head = $signed(a_st.head);
  assign b_head = $signed(b_st.head);

  // Equal heads: emit once, pop both sides
  always_comb begin
    pick_a = 1'b0;
    pick_b = 1'b0;
    priority if (a_st.head_vld && b_st.head_vld) begin
      pick_a = (a_head >= b_head);
      pick_b = (b_head >= a_head);
    end else if (a_st.head_vld) begin
      pick_a = 1'b1;
    end else begin
      pick_b = b_st.head_vld;
    end
  end

  assign rem_a = pick_a ? a_st.next_vld : a_st.head_vld;
  assign rem_b = pick_b ? b_st.next_vld : b_st.head_vld;

  assign has_value = a_st.head_vld || b_st.head_vld;
  assign value_res = pick_a ? a_head : (pick_b ? b_head : '0);
  assign last      = !rem_a && !rem_b;
  assign overflow  = dropped;

  assign a_cmd.ins = in_acc && (mode_t'(mode) == MODE_INS_A) && !a_st.full;
  assign b_cmd.ins = in_acc && (mode_t'(mode) == MODE_INS_B) && !b_st.full;
  assign a_cmd.pop = out_acc && pick_a;
  assign b_cmd.pop = out_acc && pick_b;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && (mode_t'(mode) == MODE_UNION)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc && last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dropped <= 1'b0;
    end else if (out_acc && last) begin
      dropped <= 1'b0;
    end else if (in_acc && ((mode_t'(mode) == MODE_INS_A && a_st.full) ||
                            (mode_t'(mode) == MODE_INS_B && b_st.full))) begin
      dropped <= 1'b1;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken during union emission");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_value) |-> last)
    else $error("empty union result without last mark");

  a_sets_cleared: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> (!a_st.head_vld && !b_st.head_vld && !overflow))
    else $error("sets or overflow not cleared after union run");

  a_pop_has_value: assert property (@(posedge clk) disable iff (rst)
    (a_cmd.pop || b_cmd.pop) |-> (out_valid && has_value))
    else $error("chain popped without an element on the output");

endmodule

>>> rtl/ssum_cell.sv
// One cell of a sorted chain: holds one element and its valid bit.
// Depends on ssum_pkg; instantiated by ssum_chain.
module ssum_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  ssum_pkg::chain_cmd_t              cmd,
  input  logic signed [ssum_pkg::VALUE_W-1:0] ins_val,
  input  logic                              prev_vld,
  input  logic                              prev_take,
  input  logic signed [ssum_pkg::VALUE_W-1:0] prev_val,
  input  logic                              next_vld,
  input  logic signed [ssum_pkg::VALUE_W-1:0] next_val,
  output logic                              vld,
  output logic                              take,
  output logic signed [ssum_pkg::VALUE_W-1:0] val
);
  import ssum_pkg::*;

  // Chain is kept descending; the new element lands at the first cell that
  // is empty or holds a value not above it.
  assign take = !vld || (val <= ins_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (cmd.pop) begin
      vld <= next_vld;
    end else if (cmd.ins) begin
      vld <= prev_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      val <= next_val;
    end else if (cmd.ins && take) begin
      val <= prev_take ? prev_val : ins_val;
    end
  end

endmodule

>>> rtl/ssum_chain.sv
// Row of ssum_cell instances holding one sorted set, largest at cell 0.
// Depends on ssum_pkg and ssum_cell; instantiated twice by the top level.
module ssum_chain #(
  parameter int SET_DEPTH = ssum_pkg::SSUM_SET_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ssum_pkg::chain_cmd_t              cmd,
  input  logic signed [ssum_pkg::VALUE_W-1:0] ins_val,
  output ssum_pkg::chain_stat_t             stat
);
  import ssum_pkg::*;

  logic                      vld  [SET_DEPTH];
  logic                      take [SET_DEPTH];
  logic signed [VALUE_W-1:0] val  [SET_DEPTH];

  for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
    logic                      p_vld;
    logic                      p_take;
    logic signed [VALUE_W-1:0] p_val;
    logic                      n_vld;
    logic signed [VALUE_W-1:0] n_val;

    if (i == 0) begin : g_first
      assign p_vld  = 1'b1;
      assign p_take = 1'b0;
      assign p_val  = '0;
    end else begin : g_mid
      assign p_vld  = vld[i-1];
      assign p_take = take[i-1];
      assign p_val  = val[i-1];
    end

    if (i == SET_DEPTH - 1) begin : g_last
      assign n_vld = 1'b0;
      assign n_val = '0;
    end else begin : g_inner
      assign n_vld = vld[i+1];
      assign n_val = val[i+1];
    end

    ssum_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .ins_val   (ins_val),
      .prev_vld  (p_vld),
      .prev_take (p_take),
      .prev_val  (p_val),
      .next_vld  (n_vld),
      .next_val  (n_val),
      .vld       (vld[i]),
      .take      (take[i]),
      .val       (val[i])
    );
  end

  assign stat.head     = val[0];
  assign stat.head_vld = vld[0];
  assign stat.full     = vld[SET_DEPTH-1];

  if (SET_DEPTH > 1) begin : g_next
    assign stat.next_vld = vld[1];
  end else begin : g_no_next
    assign stat.next_vld = 1'b0;
  end

endmodule
